// File: hdl/dpci_pkg.sv
package dpci_pkg;

  localparam logic [15:0] TEXT_PORT = 16'h00E9;
  localparam logic [15:0] CMD_PORT  = 16'h00EA;
  localparam logic [7:0]  END_MARK  = 8'hFF;
  localparam logic [7:0]  CHAR_LF   = 8'h0A;
  localparam logic [7:0]  CHAR_CR   = 8'h0D;
  localparam logic [7:0]  CHAR_NUL  = 8'h00;
  localparam logic [7:0]  NUM_GROUPS   = 8'd1;
  localparam logic [7:0]  NUM_COMMANDS = 8'd1;
  localparam logic [7:0]  STATUS_BAD  = 8'h00;
  localparam logic [7:0]  STATUS_GOOD = 8'h01;

  localparam logic [7:0] IDENT_BYTES [32] = '{
    8'h43, 8'h4F, 8'h4D, 8'h4D, 8'h41, 8'h4E, 8'h44, 8'h3A,
    8'h53, 8'h46, 8'h48, 8'h42, 8'h5F, 8'h78, 8'h38, 8'h36,
    8'h45, 8'h4D, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_GROUP    = 2'd1,
    MODE_CMD      = 2'd2,
    MODE_ACCEPTED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDENT   = 2'd0,
    ST_INVALID = 2'd1,
    ST_VALID   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NL_NONE = 2'd0,
    NL_LF   = 2'd1,
    NL_CR   = 2'd2
  } nl_kind_t;

endpackage

// File: hdl/debug_port_command_interpreter.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_opcode, in_port_address, in_write_data
// out      output     out_valid/out_stall out_read_data, out_claimed
//
// One item per cycle sustained while out is not stalled; an item's result
// reaches out through the input register, then the result register.
// Decode and state update sit between the input register and result register.
// rst_n is synchronous and active low; it clears mode, status, line tracking
// and both valid flags.
// A stall on out holds the result register and then the input register;
// in_stall rises only while both are full.
module debug_port_command_interpreter #(
  parameter int IDENT_LENGTH = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_port_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_claimed
);
  import dpci_pkg::*;

  localparam logic [4:0] IdentLen = 5'(IDENT_LENGTH);

  logic        in_vld_r;
  logic        op_r;
  logic [15:0] port_r;
  logic [7:0]  data_r;

  logic        out_vld_r;
  logic [7:0]  rd_r, rd_nxt;
  logic        claim_r, claim_nxt;

  mode_t       mode_r, mode_nxt;
  status_t     status_r, status_nxt;
  logic [4:0]  rd_idx_r, rd_idx_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        mis_r, mis_nxt;
  nl_kind_t    nl_r, nl_nxt;

  logic        advance;
  logic        fire;
  logic        line_end;

  assign advance   = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_read_data = rd_r;
  assign out_claimed   = claim_r;

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    mis_nxt    = mis_r;
    nl_nxt     = nl_r;
    rd_nxt     = 8'h00;
    claim_nxt  = 1'b0;
    line_end   = 1'b0;
    if (fire) begin
      if (port_r == TEXT_PORT) begin
        claim_nxt = 1'b1;
        if (op_r) begin
          rd_nxt = TEXT_PORT[7:0];
        end else if (data_r == CHAR_LF || data_r == CHAR_CR) begin
          if (nl_r == NL_NONE) begin
            line_end = 1'b1;
            nl_nxt   = (data_r == CHAR_LF) ? NL_LF : NL_CR;
          end else if ((nl_r == NL_LF && data_r == CHAR_LF) ||
                       (nl_r == NL_CR && data_r == CHAR_CR)) begin
            line_end = 1'b1;
          end else begin
            nl_nxt = NL_NONE;
          end
        end else if (data_r != CHAR_NUL) begin
          if (!mis_r && cnt_r < IdentLen && data_r == IDENT_BYTES[cnt_r]) begin
            cnt_nxt = cnt_r + 5'd1;
          end else begin
            mis_nxt = 1'b1;
          end
        end
        if (line_end) begin
          if (!mis_r && cnt_r == IdentLen) begin
            mode_nxt   = MODE_GROUP;
            status_nxt = ST_INVALID;
          end
          cnt_nxt = 5'd0;
          mis_nxt = 1'b0;
        end
      end else if (port_r == CMD_PORT) begin
        if (op_r) begin
          claim_nxt = 1'b1;
          case (status_r)
            ST_IDENT: begin
              if (rd_idx_r < IdentLen) begin
                rd_nxt     = IDENT_BYTES[rd_idx_r];
                rd_idx_nxt = rd_idx_r + 5'd1;
              end else begin
                rd_nxt     = END_MARK;
                rd_idx_nxt = 5'd0;
              end
            end
            ST_INVALID: begin
              mode_nxt = MODE_GROUP;
              rd_nxt   = STATUS_BAD;
            end
            ST_VALID: begin
              case (mode_r)
                MODE_GROUP, MODE_CMD: begin
                  rd_nxt = STATUS_GOOD;
                end
                MODE_ACCEPTED: begin
                  mode_nxt   = MODE_IDLE;
                  status_nxt = ST_IDENT;
                  rd_nxt     = STATUS_GOOD;
                end
                default: begin
                  mode_nxt   = MODE_GROUP;
                  status_nxt = ST_INVALID;
                  rd_nxt     = STATUS_BAD;
                end
              endcase
            end
            default: begin
              rd_nxt = END_MARK;
            end
          endcase
        end else if (mode_r != MODE_IDLE) begin
          claim_nxt = 1'b1;
          case (mode_r)
            MODE_GROUP: begin
              if (data_r >= NUM_GROUPS) begin
                status_nxt = ST_INVALID;
              end else begin
                status_nxt = ST_VALID;
                mode_nxt   = MODE_CMD;
              end
            end
            MODE_CMD: begin
              if (data_r >= NUM_COMMANDS) begin
                status_nxt = ST_INVALID;
                mode_nxt   = MODE_GROUP;
              end else begin
                status_nxt = ST_VALID;
                mode_nxt   = MODE_ACCEPTED;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_IDLE;
      status_r  <= ST_IDENT;
      rd_idx_r  <= 5'd0;
      cnt_r     <= 5'd0;
      mis_r     <= 1'b0;
      nl_r      <= NL_NONE;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
      mis_r    <= mis_nxt;
      nl_r     <= nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      op_r   <= in_opcode;
      port_r <= in_port_address;
      data_r <= in_write_data;
    end
    if (fire) begin
      rd_r    <= rd_nxt;
      claim_r <= claim_nxt;
    end
  end

  a_mode_status: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) == (status_r == ST_IDENT))
    else $error("mode and status out of step");

  a_status_used: assert property (@(posedge clk) disable iff (!rst_n)
    status_r != ST_UNUSED)
    else $error("unused status code reached");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IdentLen)
    else $error("line match count past identifier length");

  a_unclaimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !claim_r |-> rd_r == 8'h00)
    else $error("unclaimed access returned data");

endmodule
